// ===== hw/rtl/sgpf_pkg.sv =====
`timescale 1ns / 1ps

package sgpf_pkg;

  // Field and datapath widths.
  localparam int POS_W  = 32;   // signed Q16.16 position
  localparam int MASS_W = 32;   // unsigned Q16.16 mass and registers
  localparam int MAG_W  = 33;   // magnitude of one offset component
  localparam int SQ_W   = 66;   // square of one offset magnitude
  localparam int S_W    = 67;   // softened squared distance, Q32.32
  localparam int OP_W   = 68;   // square root working width
  localparam int ROOT_W = 34;   // floor of the square root, Q16.16
  localparam int GM_W   = 96;   // gain times both masses
  localparam int DEN_W  = 101;  // denominator, Q48.48
  localparam int NUM_W  = 128;  // numerator per component, Q64.64
  localparam int Q_W    = 49;   // quotient with one overflow bit
  localparam int FRC_W  = 48;   // signed Q32.16 force

  // Pipeline depths.
  localparam int SQRT_STAGES = 34;
  localparam int DIV_STAGES  = 49;

  // Saturation limits of a force component.
  localparam logic [FRC_W-1:0] FRC_POS_MAX = {1'b0, {(FRC_W-1){1'b1}}};
  localparam logic [FRC_W-1:0] FRC_NEG_MAX = {1'b1, {(FRC_W-1){1'b0}}};

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_COIN = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // Register word select (address bit 2).
  localparam logic REG_GAIN = 1'b0;
  localparam logic REG_EPS  = 1'b1;

  // One pair after the front stages.
  typedef struct packed {
    logic [S_W-1:0]              s;
    logic [GM_W-1:0]             gm;
    logic [2:0][MAG_W-1:0]       mag;
    logic [2:0]                  neg;
    logic                        coin;
  } pair_t;

  // One pair ready for division.
  typedef struct packed {
    logic [DEN_W-1:0]            den;
    logic [2:0][NUM_W-1:0]       num;
    logic [2:0]                  neg;
    logic                        coin;
  } quot_t;

  // One finished result.
  typedef struct packed {
    logic [2:0][FRC_W-1:0]       frc;
    logic [1:0]                  status;
  } result_t;

endpackage

// ===== hw/rtl/sgpf_front.sv =====
`timescale 1ns / 1ps

module sgpf_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                in_v,
  input  logic [2:0][sgpf_pkg::POS_W-1:0]     src_pos,
  input  logic [2:0][sgpf_pkg::POS_W-1:0]     qry_pos,
  input  logic [sgpf_pkg::MASS_W-1:0]         src_mass,
  input  logic [sgpf_pkg::MASS_W-1:0]         qry_mass,
  input  logic [sgpf_pkg::MASS_W-1:0]         gain,
  input  logic [sgpf_pkg::MASS_W-1:0]         eps,
  output logic                                out_v,
  output sgpf_pkg::pair_t                     out_pair
);

  logic [2:0][sgpf_pkg::MAG_W-1:0] d_c;
  logic [2:0][sgpf_pkg::MAG_W-1:0] mag_c;
  logic [2:0]                      neg_c;

  logic                            v1_r;
  logic [2:0][sgpf_pkg::SQ_W-1:0]  sq1_r;
  logic [63:0]                     eps2_1_r;
  logic [63:0]                     gm1_r;
  logic [sgpf_pkg::MASS_W-1:0]     mq1_r;
  logic [2:0][sgpf_pkg::MAG_W-1:0] mag1_r;
  logic [2:0]                      neg1_r;

  logic                            v2_r;
  logic [sgpf_pkg::S_W-1:0]        s2_r;
  logic [sgpf_pkg::S_W-1:0]        s2_nxt;
  logic [63:0]                     gml2_r;
  logic [63:0]                     gmh2_r;
  logic                            coin2_r;
  logic [2:0][sgpf_pkg::MAG_W-1:0] mag2_r;
  logic [2:0]                      neg2_r;

  logic                            v3_r;
  sgpf_pkg::pair_t                 pair3_r;

  // Offsets point from the query toward the source; keep sign and magnitude.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      d_c[c]   = {src_pos[c][sgpf_pkg::POS_W-1], src_pos[c]}
               - {qry_pos[c][sgpf_pkg::POS_W-1], qry_pos[c]};
      neg_c[c] = d_c[c][sgpf_pkg::MAG_W-1];
      mag_c[c] = neg_c[c] ? (~d_c[c] + 1'b1) : d_c[c];
    end
  end

  // Stage one: squares of the offsets and of epsilon, gain times source mass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        sq1_r[c] <= sgpf_pkg::SQ_W'(mag_c[c]) * sgpf_pkg::SQ_W'(mag_c[c]);
      end
      eps2_1_r <= 64'(eps) * 64'(eps);
      gm1_r    <= 64'(gain) * 64'(src_mass);
      mq1_r    <= qry_mass;
      mag1_r   <= mag_c;
      neg1_r   <= neg_c;
    end
  end

  // Stage two: sum of squares, partial products of the mass term.
  assign s2_nxt = sgpf_pkg::S_W'(eps2_1_r) + sgpf_pkg::S_W'(sq1_r[0])
                + sgpf_pkg::S_W'(sq1_r[1]) + sgpf_pkg::S_W'(sq1_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r    <= s2_nxt;
      coin2_r <= (s2_nxt == '0);
      gml2_r  <= 64'(gm1_r[31:0]) * 64'(mq1_r);
      gmh2_r  <= 64'(gm1_r[63:32]) * 64'(mq1_r);
      mag2_r  <= mag1_r;
      neg2_r  <= neg1_r;
    end
  end

  // Stage three: combine the mass partial products.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pair3_r.s    <= s2_r;
      pair3_r.gm   <= sgpf_pkg::GM_W'(gml2_r) + {gmh2_r, 32'b0};
      pair3_r.mag  <= mag2_r;
      pair3_r.neg  <= neg2_r;
      pair3_r.coin <= coin2_r;
    end
  end

  assign out_v    = v3_r;
  assign out_pair = pair3_r;

endmodule

// ===== hw/rtl/sgpf_sqrt.sv =====
`timescale 1ns / 1ps

module sgpf_sqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic                           in_v,
  input  sgpf_pkg::pair_t                in_pair,
  output logic                           out_v,
  output sgpf_pkg::pair_t                out_pair,
  output logic [sgpf_pkg::ROOT_W-1:0]    out_root
);

  localparam int LAST = sgpf_pkg::SQRT_STAGES - 1;

  logic [sgpf_pkg::OP_W-1:0] op_r  [0:LAST-1];
  logic [sgpf_pkg::OP_W-1:0] res_r [0:LAST];
  sgpf_pkg::pair_t           pair_r[0:LAST];
  logic                      v_r   [0:LAST];

  // One result bit per stage, restoring digit-by-digit square root.
  for (genvar k = 0; k < sgpf_pkg::SQRT_STAGES; k++) begin : g_stage
    localparam logic [sgpf_pkg::OP_W-1:0] ONE =
      sgpf_pkg::OP_W'(1) << (2 * (LAST - k));

    logic [sgpf_pkg::OP_W-1:0] op_in;
    logic [sgpf_pkg::OP_W-1:0] res_in;
    logic [sgpf_pkg::OP_W-1:0] trial;
    logic [sgpf_pkg::OP_W-1:0] op_nxt;
    logic [sgpf_pkg::OP_W-1:0] res_nxt;
    sgpf_pkg::pair_t           p_in;
    logic                      v_in;

    if (k == 0) begin : g_first
      assign op_in  = sgpf_pkg::OP_W'(in_pair.s);
      assign res_in = '0;
      assign p_in   = in_pair;
      assign v_in   = in_v;
    end else begin : g_next
      assign op_in  = op_r[k-1];
      assign res_in = res_r[k-1];
      assign p_in   = pair_r[k-1];
      assign v_in   = v_r[k-1];
    end

    always_comb begin
      trial = res_in + ONE;
      if (op_in >= trial) begin
        op_nxt  = op_in - trial;
        res_nxt = (res_in >> 1) + ONE;
      end else begin
        op_nxt  = op_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        res_r[k]  <= res_nxt;
        pair_r[k] <= p_in;
      end
    end

    // The remainder is not needed after the last bit.
    if (k < LAST) begin : g_op
      always_ff @(posedge clk) begin
        if (adv) begin
          op_r[k] <= op_nxt;
        end
      end
    end
  end

  assign out_v    = v_r[LAST];
  assign out_pair = pair_r[LAST];
  assign out_root = res_r[LAST][sgpf_pkg::ROOT_W-1:0];

endmodule

// ===== hw/rtl/sgpf_mul.sv =====
`timescale 1ns / 1ps

module sgpf_mul (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic                           in_v,
  input  sgpf_pkg::pair_t                in_pair,
  input  logic [sgpf_pkg::ROOT_W-1:0]    in_root,
  output logic                           out_v,
  output sgpf_pkg::quot_t                out_quot
);

  logic                        v1_r;
  logic [67:0]                 dlo1_r;
  logic [66:0]                 dhi1_r;
  logic [2:0][2:0][64:0]       pp1_r;
  logic [2:0]                  neg1_r;
  logic                        coin1_r;

  logic                        v2_r;
  sgpf_pkg::quot_t             quot2_r;

  // Stage one: partial products of the denominator and the three numerators.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dlo1_r <= 68'(in_pair.s[33:0]) * 68'(in_root);
      dhi1_r <= 67'(in_pair.s[66:34]) * 67'(in_root);
      for (int c = 0; c < 3; c++) begin
        for (int j = 0; j < 3; j++) begin
          pp1_r[c][j] <= 65'(in_pair.gm[32*j +: 32]) * 65'(in_pair.mag[c]);
        end
      end
      neg1_r  <= in_pair.neg;
      coin1_r <= in_pair.coin;
    end
  end

  // Stage two: sum the partial products.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      quot2_r.den <= sgpf_pkg::DEN_W'(dlo1_r) + (sgpf_pkg::DEN_W'(dhi1_r) << 34);
      for (int c = 0; c < 3; c++) begin
        quot2_r.num[c] <= sgpf_pkg::NUM_W'(pp1_r[c][0])
                        + (sgpf_pkg::NUM_W'(pp1_r[c][1]) << 32)
                        + (sgpf_pkg::NUM_W'(pp1_r[c][2]) << 64);
      end
      quot2_r.neg  <= neg1_r;
      quot2_r.coin <= coin1_r;
    end
  end

  assign out_v    = v2_r;
  assign out_quot = quot2_r;

endmodule

// ===== hw/rtl/sgpf_div.sv =====
`timescale 1ns / 1ps

module sgpf_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_v,
  input  sgpf_pkg::quot_t      in_quot,
  output logic                 out_v,
  output sgpf_pkg::result_t    out_res
);

  localparam int LAST  = sgpf_pkg::DIV_STAGES - 1;
  localparam int EXT_W = sgpf_pkg::DEN_W + sgpf_pkg::Q_W - 1;

  logic [sgpf_pkg::DEN_W-1:0]          den_r [0:LAST-1];
  logic [2:0][sgpf_pkg::NUM_W-1:0]     rem_r [0:LAST-1];
  logic [2:0][sgpf_pkg::Q_W-1:0]       q_r   [0:LAST];
  logic [2:0]                          neg_r [0:LAST];
  logic                                coin_r[0:LAST];
  logic                                v_r   [0:LAST];

  logic                                res_v_r;
  sgpf_pkg::result_t                   res_r;
  sgpf_pkg::result_t                   res_nxt;

  // One quotient bit per stage and lane; the first bit marks overflow.
  for (genvar k = 0; k < sgpf_pkg::DIV_STAGES; k++) begin : g_stage
    logic [sgpf_pkg::DEN_W-1:0]      den_in;
    logic [2:0][sgpf_pkg::NUM_W-1:0] rem_in;
    logic [2:0][sgpf_pkg::NUM_W-1:0] rem_nxt;
    logic [2:0][sgpf_pkg::Q_W-1:0]   q_in;
    logic [2:0][sgpf_pkg::Q_W-1:0]   q_nxt;
    logic [2:0]                      neg_in;
    logic                            coin_in;
    logic                            v_in;
    logic [EXT_W-1:0]                den_sh;

    if (k == 0) begin : g_first
      assign den_in  = in_quot.den;
      assign rem_in  = in_quot.num;
      assign q_in    = '0;
      assign neg_in  = in_quot.neg;
      assign coin_in = in_quot.coin;
      assign v_in    = in_v;
    end else begin : g_next
      assign den_in  = den_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign q_in    = q_r[k-1];
      assign neg_in  = neg_r[k-1];
      assign coin_in = coin_r[k-1];
      assign v_in    = v_r[k-1];
    end

    assign den_sh = EXT_W'(den_in) << (LAST - k);

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        if (EXT_W'(rem_in[c]) >= den_sh) begin
          rem_nxt[c] = rem_in[c] - den_sh[sgpf_pkg::NUM_W-1:0];
          q_nxt[c]   = {q_in[c][sgpf_pkg::Q_W-2:0], 1'b1};
        end else begin
          rem_nxt[c] = rem_in[c];
          q_nxt[c]   = {q_in[c][sgpf_pkg::Q_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        q_r[k]    <= q_nxt;
        neg_r[k]  <= neg_in;
        coin_r[k] <= coin_in;
      end
    end

    // Divisor and remainder are not needed after the last bit.
    if (k < LAST) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          den_r[k] <= den_in;
          rem_r[k] <= rem_nxt;
        end
      end
    end
  end

  // Apply signs, clamp to the Q32.16 range and pick the status.
  always_comb begin
    logic [2:0]                sat;
    logic [sgpf_pkg::FRC_W-1:0] q48;
    sat     = '0;
    res_nxt = '0;
    for (int c = 0; c < 3; c++) begin
      q48 = q_r[LAST][c][sgpf_pkg::FRC_W-1:0];
      if (neg_r[LAST][c]) begin
        sat[c] = q_r[LAST][c][sgpf_pkg::Q_W-1] || (q48 > sgpf_pkg::FRC_NEG_MAX);
        res_nxt.frc[c] = sat[c] ? sgpf_pkg::FRC_NEG_MAX : (~q48 + 1'b1);
      end else begin
        sat[c] = q_r[LAST][c][sgpf_pkg::Q_W-1] || (q48 > sgpf_pkg::FRC_POS_MAX);
        res_nxt.frc[c] = sat[c] ? sgpf_pkg::FRC_POS_MAX : q48;
      end
    end
    if (coin_r[LAST]) begin
      res_nxt.frc    = '0;
      res_nxt.status = sgpf_pkg::ST_COIN;
    end else if (sat != 3'b000) begin
      res_nxt.status = sgpf_pkg::ST_SAT;
    end else begin
      res_nxt.status = sgpf_pkg::ST_OK;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
    end else if (adv) begin
      res_v_r <= v_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_v   = res_v_r;
  assign out_res = res_r;

endmodule

// ===== hw/rtl/softened_gravity_point_force.sv =====
`timescale 1ns / 1ps

// Softened point-mass force on a query body from a source body, one pair per request.
// The pipeline takes a new request every cycle unless held; each accepted request passes through
// three front stages (offsets, squares, mass product), 34 square-root
// stages (one root bit each), two product stages for numerator and denominator, 49
// division stages (one quotient bit each, all three axes in parallel) and the output
// register. The whole pipeline holds only while a result waits at the output, so a
// new request is taken whenever the output register is empty or being read. Register
// 0 at byte address 0 is the gravity gain, register 1 at byte address 4 is the
// softening length; both are unsigned Q16.16 and should be written while idle.

module softened_gravity_point_force (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [sgpf_pkg::POS_W-1:0]  in_source_x,
  input  logic signed [sgpf_pkg::POS_W-1:0]  in_source_y,
  input  logic signed [sgpf_pkg::POS_W-1:0]  in_source_z,
  input  logic [sgpf_pkg::MASS_W-1:0]        in_source_mass,
  input  logic signed [sgpf_pkg::POS_W-1:0]  in_query_x,
  input  logic signed [sgpf_pkg::POS_W-1:0]  in_query_y,
  input  logic signed [sgpf_pkg::POS_W-1:0]  in_query_z,
  input  logic [sgpf_pkg::MASS_W-1:0]        in_query_mass,

  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [sgpf_pkg::FRC_W-1:0]  out_force_x,
  output logic signed [sgpf_pkg::FRC_W-1:0]  out_force_y,
  output logic signed [sgpf_pkg::FRC_W-1:0]  out_force_z,
  output logic [1:0]                         out_status,

  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [2:0]                         cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);

  logic                         adv;
  logic [sgpf_pkg::MASS_W-1:0]  gain_r;
  logic [sgpf_pkg::MASS_W-1:0]  eps_r;
  logic                         cfg_wr;

  logic                         fr_v;
  sgpf_pkg::pair_t              fr_pair;
  logic                         sq_v;
  sgpf_pkg::pair_t              sq_pair;
  logic [sgpf_pkg::ROOT_W-1:0]  sq_root;
  logic                         mu_v;
  sgpf_pkg::quot_t              mu_quot;
  logic                         dv_v;
  sgpf_pkg::result_t            dv_res;

  // Configuration registers; address bit 2 selects the word.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == sgpf_pkg::REG_EPS) ? eps_r : gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= 32'h0001_0000;
      eps_r  <= '0;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == sgpf_pkg::REG_GAIN) begin
        gain_r <= cfg_pwdata;
      end else begin
        eps_r <= cfg_pwdata;
      end
    end
  end

  // The pipeline moves unless a finished result is waiting.
  assign adv      = !dv_v || out_ready;
  assign in_ready = adv;

  sgpf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (in_valid),
    .src_pos  ({in_source_z, in_source_y, in_source_x}),
    .qry_pos  ({in_query_z, in_query_y, in_query_x}),
    .src_mass (in_source_mass),
    .qry_mass (in_query_mass),
    .gain     (gain_r),
    .eps      (eps_r),
    .out_v    (fr_v),
    .out_pair (fr_pair)
  );

  sgpf_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (fr_v),
    .in_pair  (fr_pair),
    .out_v    (sq_v),
    .out_pair (sq_pair),
    .out_root (sq_root)
  );

  sgpf_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (sq_v),
    .in_pair  (sq_pair),
    .in_root  (sq_root),
    .out_v    (mu_v),
    .out_quot (mu_quot)
  );

  sgpf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (mu_v),
    .in_quot  (mu_quot),
    .out_v    (dv_v),
    .out_res  (dv_res)
  );

  assign out_valid   = dv_v;
  assign out_force_x = dv_res.frc[0];
  assign out_force_y = dv_res.frc[1];
  assign out_force_z = dv_res.frc[2];
  assign out_status  = dv_res.status;

  // A coincident pair always carries a zero force.
  a_coin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == sgpf_pkg::ST_COIN) |->
      (out_force_x == '0) && (out_force_y == '0) && (out_force_z == '0))
    else $error("coincident result with nonzero force");

  // A saturated result has at least one component at a limit.
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == sgpf_pkg::ST_SAT) |->
      (out_force_x == sgpf_pkg::FRC_POS_MAX) || (out_force_x == sgpf_pkg::FRC_NEG_MAX) ||
      (out_force_y == sgpf_pkg::FRC_POS_MAX) || (out_force_y == sgpf_pkg::FRC_NEG_MAX) ||
      (out_force_z == sgpf_pkg::FRC_POS_MAX) || (out_force_z == sgpf_pkg::FRC_NEG_MAX))
    else $error("saturated status without a clamped component");

  // A gain write lands in the register on the next cycle.
  a_gain_wr: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && (cfg_paddr[2] == sgpf_pkg::REG_GAIN) |=> gain_r == $past(cfg_pwdata))
    else $error("gain register write lost");

endmodule

// ===== tb/sgpf_checker.sv =====
`timescale 1ns / 1ps

module sgpf_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic signed [sgpf_pkg::POS_W-1:0]  in_source_x,
  input  logic signed [sgpf_pkg::POS_W-1:0]  in_source_y,
  input  logic signed [sgpf_pkg::POS_W-1:0]  in_source_z,
  input  logic [sgpf_pkg::MASS_W-1:0]        in_source_mass,
  input  logic signed [sgpf_pkg::POS_W-1:0]  in_query_x,
  input  logic signed [sgpf_pkg::POS_W-1:0]  in_query_y,
  input  logic signed [sgpf_pkg::POS_W-1:0]  in_query_z,
  input  logic [sgpf_pkg::MASS_W-1:0]        in_query_mass,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [sgpf_pkg::FRC_W-1:0]  out_force_x,
  input  logic signed [sgpf_pkg::FRC_W-1:0]  out_force_y,
  input  logic signed [sgpf_pkg::FRC_W-1:0]  out_force_z,
  input  logic [1:0]                         out_status,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [2:0]                         cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  input  logic                               cfg_pready,
  output int                                 fail_count,
  output int                                 pending_count
);

  typedef struct {
    logic [sgpf_pkg::FRC_W-1:0] fx;
    logic [sgpf_pkg::FRC_W-1:0] fy;
    logic [sgpf_pkg::FRC_W-1:0] fz;
    logic [1:0]                 status;
  } pair_force_t;

  logic [31:0]  gain_copy;
  logic [31:0]  eps_copy;
  pair_force_t  expected_forces[$];

  // Force on the query body for one pair, computed with wide exact integers.
  function automatic pair_force_t pair_force(
    input logic [31:0] sx, input logic [31:0] sy, input logic [31:0] sz,
    input logic [31:0] sm, input logic [31:0] qx, input logic [31:0] qy,
    input logic [31:0] qz, input logic [31:0] qm,
    input logic [31:0] gain, input logic [31:0] eps);
    logic [32:0]  dif [3];
    logic         neg [3];
    logic [255:0] mag [3];
    logic [255:0] s, r, c, den, gm, q;
    logic [sgpf_pkg::FRC_W-1:0] v [3];
    logic         sat;
    pair_force_t  res;
    dif[0] = {sx[31], sx} - {qx[31], qx};
    dif[1] = {sy[31], sy} - {qy[31], qy};
    dif[2] = {sz[31], sz} - {qz[31], qz};
    s = 256'(eps) * 256'(eps);
    for (int k = 0; k < 3; k++) begin
      neg[k] = dif[k][32];
      mag[k] = neg[k] ? 256'(33'(-dif[k])) : 256'(dif[k]);
      s = s + mag[k] * mag[k];
    end
    if (s == 0) begin
      res.fx = '0;
      res.fy = '0;
      res.fz = '0;
      res.status = sgpf_pkg::ST_COIN;
      return res;
    end
    // Truncated square root, one bit at a time from the top.
    r = 0;
    for (int b = 34; b >= 0; b--) begin
      c = r | (256'd1 << b);
      if (c * c <= s) r = c;
    end
    den = s * r;
    gm = 256'(gain) * 256'(sm) * 256'(qm);
    sat = 1'b0;
    for (int k = 0; k < 3; k++) begin
      q = (gm * mag[k]) / den;
      if (neg[k]) begin
        if (q > 256'(sgpf_pkg::FRC_NEG_MAX)) begin
          q = 256'(sgpf_pkg::FRC_NEG_MAX);
          sat = 1'b1;
        end
        v[k] = sgpf_pkg::FRC_W'(-q);
      end else begin
        if (q > 256'(sgpf_pkg::FRC_POS_MAX)) begin
          q = 256'(sgpf_pkg::FRC_POS_MAX);
          sat = 1'b1;
        end
        v[k] = sgpf_pkg::FRC_W'(q);
      end
    end
    res.fx = v[0];
    res.fy = v[1];
    res.fz = v[2];
    res.status = sat ? sgpf_pkg::ST_SAT : sgpf_pkg::ST_OK;
    return res;
  endfunction

  assign pending_count = expected_forces.size();

  // Track register writes, predict each request and compare each result.
  always @(posedge clk) begin
    pair_force_t want;
    if (!rst_n) begin
      gain_copy <= 32'd65536;
      eps_copy <= 32'd0;
      fail_count <= 0;
      expected_forces.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == sgpf_pkg::REG_GAIN) gain_copy <= cfg_pwdata;
        else eps_copy <= cfg_pwdata;
      end
      if (in_valid && in_ready)
        expected_forces.push_back(pair_force(in_source_x, in_source_y, in_source_z,
          in_source_mass, in_query_x, in_query_y, in_query_z, in_query_mass,
          gain_copy, eps_copy));
      if (out_valid && out_ready) begin
        if (expected_forces.size() == 0) begin
          $error("result with no request outstanding");
          fail_count <= fail_count + 1;
        end else begin
          want = expected_forces.pop_front();
          if (out_force_x !== want.fx || out_force_y !== want.fy ||
              out_force_z !== want.fz || out_status !== want.status) begin
            fail_count <= fail_count + 1;
            if (out_force_x !== want.fx)
              $error("force_x expected %h got %h", want.fx, out_force_x);
            if (out_force_y !== want.fy)
              $error("force_y expected %h got %h", want.fy, out_force_y);
            if (out_force_z !== want.fz)
              $error("force_z expected %h got %h", want.fz, out_force_z);
            if (out_status !== want.status)
              $error("status expected %0d got %0d", want.status, out_status);
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int DRAIN_CYCLES = 100;
  localparam int STALL_LIMIT  = 20000;

  logic clk;
  logic rst_n;
  logic in_valid, in_ready;
  logic signed [sgpf_pkg::POS_W-1:0] in_source_x, in_source_y, in_source_z;
  logic signed [sgpf_pkg::POS_W-1:0] in_query_x, in_query_y, in_query_z;
  logic [sgpf_pkg::MASS_W-1:0] in_source_mass, in_query_mass;
  logic out_valid, out_ready;
  logic signed [sgpf_pkg::FRC_W-1:0] out_force_x, out_force_y, out_force_z;
  logic [1:0] out_status;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [2:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  int fail_count, pending_count;
  int send_idle_pct, recv_stall_pct;
  logic long_hold;
  int quiet_cycles;

  softened_gravity_point_force u_dut (.*);

  sgpf_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: random stalls plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles with no request or result moving.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("softened_gravity_point_force: mismatch");
      $finish;
    end
  end

  task automatic send_pair(input logic [31:0] sx, input logic [31:0] sy,
                           input logic [31:0] sz, input logic [31:0] sm,
                           input logic [31:0] qx, input logic [31:0] qy,
                           input logic [31:0] qz, input logic [31:0] qm);
    in_valid <= 1'b1;
    in_source_x <= sx;
    in_source_y <= sy;
    in_source_z <= sz;
    in_source_mass <= sm;
    in_query_x <= qx;
    in_query_y <= qy;
    in_query_z <= qz;
    in_query_mass <= qm;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // Each idle cycle is drawn on its own, so the idle share matches the percentage.
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
  endtask

  // Random pair: mostly nearby bodies so forces are meaningful.
  task automatic send_random_pair();
    logic [31:0] sx, sy, sz, sm, qm;
    logic [31:0] qx, qy, qz;
    int kind;
    sx = $urandom();
    sy = $urandom();
    sz = $urandom();
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      qx = $urandom();
      qy = $urandom();
      qz = $urandom();
    end else if (kind == 3) begin
      qx = sx;
      qy = sy;
      qz = sz;
    end else begin
      qx = sx + $signed($urandom_range(0, 1 << 21)) - (1 << 20);
      qy = sy + $signed($urandom_range(0, 1 << 21)) - (1 << 20);
      qz = sz + $signed($urandom_range(0, 1 << 21)) - (1 << 20);
    end
    sm = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1 << 20);
    qm = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1 << 20);
    send_pair(sx, sy, sz, sm, qx, qy, qz, qm);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct,
                           input logic [31:0] gain, input logic [31:0] eps);
    drain();
    write_reg({sgpf_pkg::REG_GAIN, 2'b00}, gain);
    write_reg({sgpf_pkg::REG_EPS, 2'b00}, eps);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < 240; k++) begin
      if (idle_pct == 0 && stall_pct == 0 && k == 100) long_hold = 1'b1;
      send_random_pair();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    {in_source_x, in_source_y, in_source_z, in_source_mass} = '0;
    {in_query_x, in_query_y, in_query_z, in_query_mass} = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    long_hold = 1'b0;
    quiet_cycles = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pairs at reset settings: coincident, zero mass, extremes, signs.
    send_pair(0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000);
    send_pair(32'h7FFFFFFF, 5, 5, 32'h10000, 32'h7FFFFFFF, 5, 5, 32'hFFFFFFFF);
    send_pair(32'h10000, 0, 0, 32'h10000, 0, 0, 0, 32'h10000);
    send_pair(0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h10000);
    send_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF,
              32'h80000000, 32'h80000000, 32'h80000000, 32'hFFFFFFFF);
    send_pair(32'h80000000, 32'h80000000, 32'h80000000, 32'hFFFFFFFF,
              32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF);
    send_pair(1, 0, 0, 32'hFFFFFFFF, 0, 0, 0, 32'hFFFFFFFF);
    send_pair(0, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0, 32'hFFFFFFFF);
    send_pair(32'h30000, 32'hFFFC0000, 32'h50000, 0, 0, 0, 0, 32'hFFFFFFFF);
    send_pair(32'h30000, 32'hFFFC0000, 32'h50000, 32'hFFFFFFFF, 0, 0, 0, 0);
    send_pair(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555,
              32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA);

    // Zero gain, then maximum softening against coincident bodies.
    drain();
    write_reg({sgpf_pkg::REG_GAIN, 2'b00}, 32'd0);
    send_pair(32'h10000, 0, 0, 32'h10000, 0, 0, 0, 32'h10000);
    drain();
    write_reg({sgpf_pkg::REG_GAIN, 2'b00}, 32'hFFFFFFFF);
    write_reg({sgpf_pkg::REG_EPS, 2'b00}, 32'hFFFFFFFF);
    send_pair(0, 0, 0, 32'hFFFFFFFF, 0, 0, 0, 32'hFFFFFFFF);
    send_pair(32'h7FFFFFFF, 0, 0, 32'hFFFFFFFF, 32'h80000000, 0, 0, 32'hFFFFFFFF);
    drain();
    write_reg({sgpf_pkg::REG_EPS, 2'b00}, 32'd1);
    send_pair(5, 5, 5, 32'h10000, 5, 5, 5, 32'h10000);
    send_pair(1, 1, 1, 32'hFFFFFFFF, 0, 0, 0, 32'hFFFFFFFF);

    // Random phases over idling patterns and register settings.
    run_phase(0, 0, 32'd65536, 32'd0);
    run_phase(68, 0, 32'hFFFFFFFF, 32'd65536);
    run_phase(0, 68, 32'd1, 32'd1);
    run_phase(37, 37, $urandom(), $urandom_range(0, 1 << 18));

    drain();
    if (fail_count == 0 && pending_count == 0)
      $display("softened_gravity_point_force: match");
    else
      $display("softened_gravity_point_force: mismatch");
    $finish;
  end

endmodule
